### rtl/core/directional_nearest_corner_search_unit_assert.svh
//------------------------------------------------------------------------------
// Assertion macros for the directional nearest corner search unit
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
//------------------------------------------------------------------------------
`ifndef DIRECTIONAL_NEAREST_CORNER_SEARCH_UNIT_ASSERT_SVH
`define DIRECTIONAL_NEAREST_CORNER_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DNCS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("dncs assertion failed");

// Next-cycle implication.
`define DNCS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dncs assertion failed");

`endif

### rtl/core/dncs_pkg.sv
//------------------------------------------------------------------------------
// dncs_pkg
// Shared constants, codes and control types of the corner search unit.
//------------------------------------------------------------------------------
package dncs_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int COORD_W      = 16;
  localparam int DIR_W        = 16;
  localparam int WGT_W        = 4;
  localparam int COST_W       = 20;
  localparam int ADDR_W       = 3;
  localparam int DRAIN_CYCLES = 32;
  localparam int DRN_W        = 6;

  localparam logic [COST_W-1:0] COST_MAX     = 20'hFFFFF;
  localparam logic [WGT_W-1:0]  RESET_WEIGHT = 4'd5;

  localparam logic [ADDR_W-1:0] REG_ACTIVE_COUNT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_EDGE_WEIGHT  = 3'd4;

  typedef enum logic [1:0] {
    OP_WRITE_POINT = 2'd0,
    OP_WRITE_FLAG  = 2'd1,
    OP_QUERY       = 2'd2,
    OP_RESERVED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REF,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic write;
    logic query;
    logic ref_load;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_end;
    logic out_busy;
  } sts_t;

endpackage

### rtl/core/dncs_regs.sv
//------------------------------------------------------------------------------
// dncs_regs
// APB-style configuration registers: active count and edge weight.
//------------------------------------------------------------------------------
module dncs_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dncs_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [dncs_pkg::CNT_W-1:0]        active_count_o,
  output logic [dncs_pkg::WGT_W-1:0]        edge_weight_o
);

  logic [dncs_pkg::CNT_W-1:0] active_count_q;
  logic [dncs_pkg::WGT_W-1:0] edge_weight_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      edge_weight_q  <= dncs_pkg::RESET_WEIGHT;
    end else if (wr_en) begin
      unique case (paddr)
        dncs_pkg::REG_ACTIVE_COUNT: active_count_q <= pwdata[dncs_pkg::CNT_W-1:0];
        dncs_pkg::REG_EDGE_WEIGHT:  edge_weight_q  <= pwdata[dncs_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      dncs_pkg::REG_ACTIVE_COUNT: prdata = 32'(active_count_q);
      dncs_pkg::REG_EDGE_WEIGHT:  prdata = 32'(edge_weight_q);
      default:                    prdata = '0;
    endcase
  end

  assign active_count_o = active_count_q;
  assign edge_weight_o  = edge_weight_q;

endmodule

### rtl/core/dncs_ctrl.sv
//------------------------------------------------------------------------------
// dncs_ctrl
// Sequencer: clearing pass, item intake, scan, pipeline drain, result load.
//------------------------------------------------------------------------------
module dncs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     op_i,
  input  dncs_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output dncs_pkg::cmd_t cmd_o
);

  dncs_pkg::state_e           state_q, state_d;
  logic [dncs_pkg::DRN_W-1:0] drn_q, drn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dncs_pkg::ST_CLEAR;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      drn_q   <= drn_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    drn_d      = drn_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dncs_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = dncs_pkg::ST_IDLE;
      end
      dncs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (dncs_pkg::op_e'(op_i)) inside
            dncs_pkg::OP_WRITE_POINT, dncs_pkg::OP_WRITE_FLAG: cmd_o.write = 1'b1;
            dncs_pkg::OP_QUERY: begin
              cmd_o.query = 1'b1;
              state_d     = dncs_pkg::ST_REF;
            end
            default: ;
          endcase
        end
      end
      dncs_pkg::ST_REF: begin
        cmd_o.ref_load = 1'b1;
        state_d        = dncs_pkg::ST_SCAN;
      end
      dncs_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          drn_d   = '0;
          state_d = dncs_pkg::ST_DRAIN;
        end
      end
      dncs_pkg::ST_DRAIN: begin
        drn_d = drn_q + 1'b1;
        if (drn_q == dncs_pkg::DRN_W'(dncs_pkg::DRAIN_CYCLES - 1)) state_d = dncs_pkg::ST_DONE;
      end
      dncs_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = dncs_pkg::ST_IDLE;
        end
      end
      default: state_d = dncs_pkg::ST_CLEAR;
    endcase
  end

`include "directional_nearest_corner_search_unit_assert.svh"

  `DNCS_ASSERT_IMP(a_scan_follows_ref,
                   state_q == dncs_pkg::ST_SCAN && $past(state_q) != dncs_pkg::ST_SCAN,
                   $past(state_q) == dncs_pkg::ST_REF)
  `DNCS_ASSERT_IMP(a_done_after_drain,
                   state_q == dncs_pkg::ST_DONE,
                   $past(state_q) == dncs_pkg::ST_DRAIN || $past(state_q) == dncs_pkg::ST_DONE)
  `DNCS_ASSERT_IMP(a_clear_complete,
                   $past(state_q) == dncs_pkg::ST_CLEAR && state_q == dncs_pkg::ST_IDLE,
                   $past(sts_i.clear_last))
  `DNCS_ASSERT_NXT(a_load_returns_idle, cmd_o.out_load, state_q == dncs_pkg::ST_IDLE)

endmodule

### rtl/core/dncs_dpath.sv
//------------------------------------------------------------------------------
// dncs_dpath
// Point memories, pipelined cost datapath, best tracker and result register.
//------------------------------------------------------------------------------
module dncs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dncs_pkg::cmd_t                      cmd_i,
  output dncs_pkg::sts_t                      sts_o,
  input  logic [1:0]                          op_i,
  input  logic [dncs_pkg::IDX_W-1:0]          point_index_i,
  input  logic [dncs_pkg::COORD_W-1:0]        coord_x_i,
  input  logic [dncs_pkg::COORD_W-1:0]        coord_y_i,
  input  logic                                in_use_i,
  input  logic signed [dncs_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [dncs_pkg::DIR_W-1:0]   dir_y_i,
  input  logic [dncs_pkg::CNT_W-1:0]          active_count_i,
  input  logic [dncs_pkg::WGT_W-1:0]          edge_weight_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dncs_pkg::IDX_W-1:0]          neighbor_index_o,
  output logic [dncs_pkg::COST_W-1:0]         best_cost_o,
  output logic                                found_o
);

  localparam int ISQ = 21;
  localparam int SQW = 42;

  typedef struct packed {
    logic [SQW-1:0]            n;
    logic [SQW-1:0]            r;
    logic [17:0]               proj;
    logic [dncs_pkg::IDX_W-1:0] idx;
    logic                      q;
  } isq_t;

  // One restoring square-root step per pipeline stage.
  function automatic isq_t isq_step(input isq_t s, input int k);
    logic [SQW-1:0] b;
    logic [SQW-1:0] t;
    isq_t           o;
    b = SQW'(1) << (2 * (ISQ - 1 - k));
    t = s.r + b;
    o = s;
    if (s.n >= t) begin
      o.n = s.n - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  logic [dncs_pkg::COORD_W-1:0] x_mem [dncs_pkg::MAX_POINTS];
  logic [dncs_pkg::COORD_W-1:0] y_mem [dncs_pkg::MAX_POINTS];
  logic                         u_mem [dncs_pkg::MAX_POINTS];

  logic [dncs_pkg::CNT_W-1:0]   addr_q, lim_q;
  logic [dncs_pkg::IDX_W-1:0]   rd_addr, uw_addr;
  logic                         issue, addr_lt;
  logic                         uw_en, uw_data;

  logic [dncs_pkg::COORD_W-1:0] x_rd_q, y_rd_q, rx_q, ry_q;
  logic                         u_rd_q;
  logic signed [dncs_pkg::DIR_W-1:0] vx_q, vy_q;

  logic                         v1_q, v2_q, v3_q, u2_q, u3_q, q4_q, q5_q, q6_q, q7_q;
  logic [dncs_pkg::IDX_W-1:0]   i1_q, i2_q, i3_q, i4_q, i5_q, i6_q, i7_q;
  logic signed [16:0]           dx2_q, dy2_q, dx3_q, dy3_q, dx4_q, dy4_q, dx5_q, dy5_q;
  logic signed [31:0]           mx3_q, my3_q;
  logic signed [32:0]           p4_q;
  logic signed [48:0]           tx5_q, ty5_q;
  logic [17:0]                  proj5_q, proj6_q, proj7_q;
  logic signed [20:0]           ex6_q, ey6_q;
  logic [39:0]                  sqx7_q, sqy7_q;
  isq_t                         isq_q [ISQ+1];
  logic [24:0]                  wp_q;
  logic [17:0]                  projw_q;
  logic [dncs_pkg::IDX_W-1:0]   iw_q, ic_q;
  logic                         qw_q, qc_q;
  logic [dncs_pkg::COST_W-1:0]  cost_q;

  logic                         found_q;
  logic [dncs_pkg::COST_W-1:0]  best_cost_q;
  logic [dncs_pkg::IDX_W-1:0]   best_idx_q;
  logic                         out_valid_q;

  logic signed [16:0]           dx_c, dy_c;
  logic signed [32:0]           mx_full, my_full, p_full;
  logic signed [48:0]           tx_full, ty_full, tx_rnd, ty_rnd, ex_full, ey_full;
  logic signed [41:0]           sqx_full, sqy_full;
  logic [24:0]                  wp_full;
  logic [25:0]                  cost_full;

  assign addr_lt = addr_q < lim_q;
  assign issue   = cmd_i.scan && addr_lt;
  assign rd_addr = cmd_i.query ? point_index_i : addr_q[dncs_pkg::IDX_W-1:0];
  assign uw_en   = cmd_i.clear || cmd_i.write;
  assign uw_addr = cmd_i.clear ? addr_q[dncs_pkg::IDX_W-1:0] : point_index_i;
  assign uw_data = cmd_i.clear ? 1'b0 : in_use_i;

  assign sts_o.clear_last = addr_q[dncs_pkg::IDX_W-1:0] == '1;
  assign sts_o.scan_end   = !addr_lt;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && dncs_pkg::op_e'(op_i) == dncs_pkg::OP_WRITE_POINT) begin
      x_mem[point_index_i] <= coord_x_i;
      y_mem[point_index_i] <= coord_y_i;
    end
    if (uw_en) u_mem[uw_addr] <= uw_data;
    x_rd_q <= x_mem[rd_addr];
    y_rd_q <= y_mem[rd_addr];
    u_rd_q <= u_mem[addr_q[dncs_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      lim_q  <= '0;
    end else if (cmd_i.query) begin
      addr_q <= '0;
      lim_q  <= (active_count_i > dncs_pkg::CNT_W'(dncs_pkg::MAX_POINTS))
                ? dncs_pkg::CNT_W'(dncs_pkg::MAX_POINTS) : active_count_i;
    end else if (cmd_i.clear || issue) begin
      addr_q <= addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      vx_q <= dir_x_i;
      vy_q <= dir_y_i;
    end
    if (cmd_i.ref_load) begin
      rx_q <= x_rd_q;
      ry_q <= y_rd_q;
    end
  end

  // Combinational arithmetic between pipeline registers.
  assign dx_c     = $signed({1'b0, x_rd_q}) - $signed({1'b0, rx_q});
  assign dy_c     = $signed({1'b0, y_rd_q}) - $signed({1'b0, ry_q});
  assign mx_full  = dx2_q * vx_q;
  assign my_full  = dy2_q * vy_q;
  assign p_full   = mx3_q + my3_q;
  assign tx_full  = p4_q * vx_q;
  assign ty_full  = p4_q * vy_q;
  assign tx_rnd   = tx5_q + (49'sd1 <<< 27);
  assign ty_rnd   = ty5_q + (49'sd1 <<< 27);
  assign ex_full  = dx5_q - (tx_rnd >>> 28);
  assign ey_full  = dy5_q - (ty_rnd >>> 28);
  assign sqx_full = ex6_q * ex6_q;
  assign sqy_full = ey6_q * ey6_q;
  assign wp_full  = edge_weight_i * isq_q[ISQ].r[ISQ-1:0];
  assign cost_full = 26'(projw_q) + 26'(wp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      q4_q <= 1'b0;
      q5_q <= 1'b0;
      q6_q <= 1'b0;
      q7_q <= 1'b0;
      for (int k = 0; k <= ISQ; k++) isq_q[k] <= '0;
      qw_q <= 1'b0;
      qc_q <= 1'b0;
    end else begin
      v1_q <= issue;
      i1_q <= addr_q[dncs_pkg::IDX_W-1:0];
      v2_q <= v1_q;
      i2_q <= i1_q;
      u2_q <= u_rd_q;
      dx2_q <= dx_c;
      dy2_q <= dy_c;
      v3_q <= v2_q;
      i3_q <= i2_q;
      u3_q <= u2_q;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
      mx3_q <= mx_full[31:0];
      my3_q <= my_full[31:0];
      // An entry qualifies only with a strictly positive exact projection.
      q4_q <= v3_q && !u3_q && !p_full[32] && (p_full != '0);
      i4_q <= i3_q;
      p4_q <= p_full;
      dx4_q <= dx3_q;
      dy4_q <= dy3_q;
      q5_q <= q4_q;
      i5_q <= i4_q;
      proj5_q <= p4_q[31:14];
      tx5_q <= tx_full;
      ty5_q <= ty_full;
      dx5_q <= dx4_q;
      dy5_q <= dy4_q;
      q6_q <= q5_q;
      i6_q <= i5_q;
      proj6_q <= proj5_q;
      ex6_q <= ex_full[20:0];
      ey6_q <= ey_full[20:0];
      q7_q <= q6_q;
      i7_q <= i6_q;
      proj7_q <= proj6_q;
      sqx7_q <= sqx_full[39:0];
      sqy7_q <= sqy_full[39:0];
      isq_q[0].n    <= SQW'(sqx7_q) + SQW'(sqy7_q);
      isq_q[0].r    <= '0;
      isq_q[0].proj <= proj7_q;
      isq_q[0].idx  <= i7_q;
      isq_q[0].q    <= q7_q;
      for (int k = 0; k < ISQ; k++) isq_q[k+1] <= isq_step(isq_q[k], k);
      qw_q <= isq_q[ISQ].q;
      iw_q <= isq_q[ISQ].idx;
      projw_q <= isq_q[ISQ].proj;
      wp_q <= wp_full;
      qc_q <= qw_q;
      ic_q <= iw_q;
      cost_q <= (cost_full > 26'(dncs_pkg::COST_MAX)) ? dncs_pkg::COST_MAX
                                                       : cost_full[dncs_pkg::COST_W-1:0];
    end
  end

  // Best tracker: strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_cost_q <= dncs_pkg::COST_MAX;
      best_idx_q  <= '0;
    end else if (cmd_i.query) begin
      found_q     <= 1'b0;
      best_cost_q <= dncs_pkg::COST_MAX;
      best_idx_q  <= '0;
    end else if (qc_q && (!found_q || cost_q < best_cost_q)) begin
      found_q     <= 1'b1;
      best_cost_q <= cost_q;
      best_idx_q  <= ic_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      neighbor_index_o <= best_idx_q;
      best_cost_o      <= best_cost_q;
      found_o          <= found_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/directional_nearest_corner_search_unit.sv
//------------------------------------------------------------------------------
// directional_nearest_corner_search_unit
// Top level: configuration registers, sequencer and search datapath.
//------------------------------------------------------------------------------
// The unit keeps a table of 1024 corner points and answers directional
// nearest-neighbor queries over it. After reset it clears the used flags of
// all 1024 entries and takes no item during that pass; configuration writes
// are taken at all times. A write item (op 0 or 1) is taken while idle and
// the unit stays idle. A query scans one table entry per cycle through a
// pipelined cost datapath (projection, perpendicular remainder, a 21-stage
// square root, weighting, compare), and the unit takes no further item until
// the query is through: it reads the reference point, scans the entries below
// min(active_count, 1024), sees the end of the range, drains the pipeline and
// loads the result register, after any wait for an earlier result still in
// that register. The result register lets write items be taken while a result
// still waits; a second query finishes its scan but holds its result until
// the first one is taken. Items with op 3 are taken and dropped.
module directional_nearest_corner_search_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dncs_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [dncs_pkg::IDX_W-1:0]          point_index_i,
  input  logic [dncs_pkg::COORD_W-1:0]        coord_x_i,
  input  logic [dncs_pkg::COORD_W-1:0]        coord_y_i,
  input  logic                                in_use_i,
  input  logic signed [dncs_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [dncs_pkg::DIR_W-1:0]   dir_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dncs_pkg::IDX_W-1:0]          neighbor_index_o,
  output logic [dncs_pkg::COST_W-1:0]         best_cost_o,
  output logic                                found_o
);

  // Register values seen by the datapath.
  logic [dncs_pkg::CNT_W-1:0] active_count;
  logic [dncs_pkg::WGT_W-1:0] edge_weight;

  // Command and status between the sequencer and the datapath.
  dncs_pkg::cmd_t cmd;
  dncs_pkg::sts_t sts;

  dncs_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .active_count_o (active_count),
    .edge_weight_o  (edge_weight)
  );

  // The sequencer decides when an item is taken and steps the scan.
  dncs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the point table, the cost pipeline and the result.
  dncs_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .point_index_i    (point_index_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .in_use_i         (in_use_i),
    .dir_x_i          (dir_x_i),
    .dir_y_i          (dir_y_i),
    .active_count_i   (active_count),
    .edge_weight_i    (edge_weight),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neighbor_index_o (neighbor_index_o),
    .best_cost_o      (best_cost_o),
    .found_o          (found_o)
  );

endmodule

### sim/dncs_search_checker.sv
//------------------------------------------------------------------------------
// Corner search result checker
// Watches the register port and both item channels, predicts each query answer
// from its own copy of the point table and compares it with what comes out.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module dncs_search_checker
  import dncs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [31:0]               pwdata,
  input  logic                      pready,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                op_i,
  input  logic [IDX_W-1:0]          point_index_i,
  input  logic [COORD_W-1:0]        coord_x_i,
  input  logic [COORD_W-1:0]        coord_y_i,
  input  logic                      in_use_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [IDX_W-1:0]          neighbor_index_i,
  input  logic [COST_W-1:0]         best_cost_i,
  input  logic                      found_i,
  output int                        fail_count_o,
  output int                        pending_count_o,
  output int                        result_count_o,
  output int                        found_count_o
);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [COST_W-1:0] cost;
    logic              found;
  } answer_t;

  logic [COORD_W-1:0] table_x [MAX_POINTS];
  logic [COORD_W-1:0] table_y [MAX_POINTS];
  logic               table_used [MAX_POINTS];
  logic [CNT_W-1:0]   scan_count;
  logic [WGT_W-1:0]   cost_weight;
  answer_t            answer_q [$];

  function automatic longint round_q28(longint t);
    return (t + (longint'(1) <<< 27)) >>> 28;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scans the unused entries below the active count and keeps the cheapest
  // one with a positive projection; strict less-than keeps the lowest index.
  function automatic answer_t search_nearest(logic [IDX_W-1:0] ref_idx,
                                             logic signed [DIR_W-1:0] dx_dir,
                                             logic signed [DIR_W-1:0] dy_dir);
    answer_t ans;
    longint vx, vy, rx, ry, dx, dy, p, ex, ey, cost;
    longint unsigned perp;
    int lim;
    ans = '{idx: '0, cost: COST_MAX, found: 1'b0};
    vx = longint'(dx_dir);
    vy = longint'(dy_dir);
    rx = longint'(table_x[ref_idx]);
    ry = longint'(table_y[ref_idx]);
    lim = (scan_count > MAX_POINTS) ? MAX_POINTS : int'(scan_count);
    for (int i = 0; i < lim; i++) begin
      if (table_used[i]) continue;
      dx = longint'(table_x[i]) - rx;
      dy = longint'(table_y[i]) - ry;
      p = dx * vx + dy * vy;
      if (p <= 0) continue;
      ex = dx - round_q28(p * vx);
      ey = dy - round_q28(p * vy);
      perp = int_sqrt(longint'(ex * ex + ey * ey));
      cost = (p >>> 14) + longint'(cost_weight) * longint'(perp);
      if (cost > longint'(COST_MAX)) cost = longint'(COST_MAX);
      if (!ans.found || cost < longint'(ans.cost)) begin
        ans.found = 1'b1;
        ans.cost  = cost[COST_W-1:0];
        ans.idx   = i[IDX_W-1:0];
      end
    end
    return ans;
  endfunction

  assign pending_count_o = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) table_used[i] = 1'b0;
      scan_count = '0;
      cost_weight = RESET_WEIGHT;
      answer_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
      found_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_ACTIVE_COUNT: scan_count = pwdata[CNT_W-1:0];
          REG_EDGE_WEIGHT:  cost_weight = pwdata[WGT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (op_e'(op_i))
          OP_WRITE_POINT: begin
            table_x[point_index_i] = coord_x_i;
            table_y[point_index_i] = coord_y_i;
            table_used[point_index_i] = in_use_i;
          end
          OP_WRITE_FLAG: table_used[point_index_i] = in_use_i;
          OP_QUERY: answer_q = {answer_q, search_nearest(point_index_i, dir_x_i, dir_y_i)};
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (found_i) found_count_o++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d cost=%0d found=%0b", $time,
                   neighbor_index_i, best_cost_i, found_i);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          if (want.found !== found_i) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_i);
            fail_count_o++;
          end
          if (want.idx !== neighbor_index_i) begin
            $display("%0t: neighbor_index expected %0d actual %0d", $time, want.idx,
                     neighbor_index_i);
            fail_count_o++;
          end
          if (want.cost !== best_cost_i) begin
            $display("%0t: best_cost expected %0d actual %0d", $time, want.cost,
                     best_cost_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

### sim/tb_directional_nearest_corner_search_unit.sv
//------------------------------------------------------------------------------
// Testbench for the directional nearest corner search unit
// Loads the low part of the point table, runs directed corner cases, then
// random phases under many register settings; a separate checker predicts
// every answer.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_directional_nearest_corner_search_unit;
  import dncs_pkg::*;

  // Generous bound: table load, all phases with worst stalls, several times over.
  localparam int CYCLE_LIMIT = 1500000;
  // Entries loaded at the start; every query and scan stays inside them.
  localparam int LOAD_COUNT = 128;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel, penable, pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid_i, in_ready_o;
  logic [1:0]               op_i;
  logic [IDX_W-1:0]         point_index_i;
  logic [COORD_W-1:0]       coord_x_i, coord_y_i;
  logic                     in_use_i;
  logic signed [DIR_W-1:0]  dir_x_i, dir_y_i;
  logic                     out_valid_o, out_ready_i;
  logic [IDX_W-1:0]         neighbor_index_o;
  logic [COST_W-1:0]        best_cost_o;
  logic                     found_o;

  int  fail_count, pending_count, result_count, found_count;
  int  cycle_count = 0;
  int  query_count = 0;
  int  write_count = 0;
  int  setting_count = 0;
  // When set, both sides run back to back with no idle cycles.
  bit  burst_mode = 1'b0;

  always #2 clk_i = ~clk_i;

  directional_nearest_corner_search_unit DUT (.*);

  dncs_search_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .point_index_i, .coord_x_i,
    .coord_y_i, .in_use_i, .dir_x_i, .dir_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .neighbor_index_i(neighbor_index_o),
    .best_cost_i(best_cost_o), .found_i(found_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .result_count_o(result_count), .found_count_o(found_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** directional_nearest_corner_search_unit: FAILED **");
      $finish;
    end
  end

  // The result side stalls a random number of cycles before each result.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Sends one item after a random idle gap. Valid is only lowered when there
  // is a gap, so back-to-back items keep it high across the handshake edge.
  task automatic send_item(op_e op, int idx, int cx, int cy, bit flag,
                           int vx, int vy);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    point_index_i <= idx[IDX_W-1:0];
    coord_x_i     <= cx[COORD_W-1:0];
    coord_y_i     <= cy[COORD_W-1:0];
    in_use_i      <= flag;
    dir_x_i       <= vx[DIR_W-1:0];
    dir_y_i       <= vy[DIR_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_QUERY) query_count++;
    else if (op != OP_RESERVED) write_count++;
  endtask

  // Waits until every answer is in and the pipeline has drained.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES + 8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, int data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_search(int count, int weight);
    wait_idle();
    reg_write(REG_ACTIVE_COUNT, count);
    reg_write(REG_EDGE_WEIGHT, weight);
    setting_count++;
  endtask

  // Mostly unit directions at random angles, sometimes any vector with both components in -16384..16384.
  task automatic pick_direction(output int vx, output int vy);
    real ang;
    if ($urandom_range(0, 99) < 85) begin
      ang = $urandom_range(0, 359999) * 3.14159265358979 / 180000.0;
      vx = $rtoi($cos(ang) * 16384.0);
      vy = $rtoi($sin(ang) * 16384.0);
    end else begin
      vx = int'($urandom_range(0, 32768)) - 16384;
      vy = int'($urandom_range(0, 32768)) - 16384;
    end
  endtask

  // Random phase: queries dominate, writes keep reshaping the scanned range.
  task automatic run_phase(int count, int weight, int items);
    int hi, idx, sel, vx, vy, cx, cy;
    set_search(count, weight);
    burst_mode = ($urandom_range(0, 3) == 0);
    hi = (count == 0) ? 15 : ((count > MAX_POINTS) ? MAX_POINTS - 1 : count - 1);
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LOAD_COUNT - 1)
                                        : $urandom_range(0, hi);
      if (sel < 60) begin
        pick_direction(vx, vy);
        send_item(OP_QUERY, idx, 0, 0, 0, vx, vy);
      end else if (sel < 88) begin
        if ($urandom_range(0, 1)) begin
          cx = $urandom_range(0, 65535);
          cy = $urandom_range(0, 65535);
        end else begin
          cx = $urandom_range(16'h7000, 16'h9000);
          cy = $urandom_range(16'h7000, 16'h9000);
        end
        send_item(OP_WRITE_POINT, idx, cx, cy, $urandom_range(0, 4) == 0, 0, 0);
      end else if (sel < 98) begin
        send_item(OP_WRITE_FLAG, idx, 0, 0, $urandom_range(0, 2) == 0, 0, 0);
      end else begin
        send_item(OP_RESERVED, idx, $urandom, $urandom, 1'($urandom), 0, 0);
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int cx, cy;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; op_i = OP_WRITE_POINT; point_index_i = '0;
    coord_x_i = '0; coord_y_i = '0; in_use_i = 1'b0; dir_x_i = '0; dir_y_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the low entries; no query below reads a point outside them.
    // The first four entries sit on the corners of the coordinate range.
    for (int i = 0; i < LOAD_COUNT; i++) begin
      cx = (i < 4) ? ((i == 1 || i == 2) ? 65535 : 0) : $urandom_range(0, 65535);
      cy = (i < 4) ? ((i == 1 || i == 3) ? 65535 : 0) : $urandom_range(0, 65535);
      send_item(OP_WRITE_POINT, i, cx, cy, (i >= 8) && ($urandom_range(0, 4) == 0), 0, 0);
    end

    // Directed part. With the reset count of zero nothing is scanned.
    send_item(OP_QUERY, 5, 0, 0, 0, 16384, 0);
    set_search(16, 15);
    // A diagonal of length sqrt(2) from the origin corner drives the cost past
    // its maximum, so saturation shows up.
    send_item(OP_QUERY, 0, 0, 0, 0, 16384, 16384);
    send_item(OP_QUERY, 1, 0, 0, 0, -16384, 0);
    send_item(OP_QUERY, 2, 0, 0, 0, 0, 16384);
    send_item(OP_QUERY, 3, 0, 0, 0, 0, -16384);
    // A zero direction gives no positive projection anywhere.
    send_item(OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_item(OP_WRITE_FLAG, 1, 0, 0, 1, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 16384, 16384);
    send_item(OP_WRITE_FLAG, 1, 0, 0, 0, 0, 0);
    send_item(OP_RESERVED, 1023, 65535, 65535, 1, -1, -1);
    // Reference point outside the scanned range.
    send_item(OP_QUERY, LOAD_COUNT - 1, 0, 0, 0, -16384, -16384);
    send_item(OP_WRITE_POINT, LOAD_COUNT - 1, 65535, 0, 1, 0, 0);
    // Two entries at the same spot tie on cost; the lower index must win.
    send_item(OP_WRITE_POINT, 6, 400, 400, 0, 0, 0);
    send_item(OP_WRITE_POINT, 7, 400, 400, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 11585, 11585);
    set_search(16, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 11585, 11585);

    // Random phases over a spread of settings, the extremes among them.
    // Scans over every loaded entry are the slowest.
    run_phase(1, 0, 30);
    run_phase(8, 15, 50);
    run_phase(40, 5, 50);
    run_phase(64, 3, 50);
    run_phase(2, 9, 40);
    run_phase(33, 1, 50);
    run_phase(17, 15, 50);
    run_phase(LOAD_COUNT, 7, 60);
    run_phase(LOAD_COUNT, 15, 30);
    run_phase(0, 5, 10);

    wait_idle();
    $display("Ran %0d queries and %0d table writes under %0d register settings.",
             query_count, write_count, setting_count);
    $display("Checked %0d results, %0d of which named a neighbor.",
             result_count, found_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** directional_nearest_corner_search_unit: PASSED **");
    end else begin
      $display("** directional_nearest_corner_search_unit: FAILED **");
    end
    $finish;
  end

endmodule

### directional_nearest_corner_search_unit.f
+incdir+rtl/core
rtl/core/dncs_pkg.sv
rtl/core/dncs_regs.sv
rtl/core/dncs_ctrl.sv
rtl/core/dncs_dpath.sv
rtl/core/directional_nearest_corner_search_unit.sv
sim/dncs_search_checker.sv
sim/tb_directional_nearest_corner_search_unit.sv
